FILE: rtl/core/rcat_pkg.sv
// Shared types, constants and register codes of the radio control-bus frame decoder.
package rcat_pkg;

  // Frame limits and storage.
  localparam int unsigned MaxFrameDefault = 64;
  localparam int unsigned KeepBytes       = 10;
  localparam int unsigned KeepIdxW        = $clog2(KeepBytes);

  // Field widths.
  localparam int unsigned ByteW   = 8;
  localparam int unsigned FreqW   = 34;
  localparam int unsigned MeterW  = 14;
  localparam int unsigned CfgIdxW = 3;

  // Special bytes on the bus.
  localparam logic [ByteW-1:0] BytePreamble  = 8'hFE;
  localparam logic [ByteW-1:0] ByteEnd       = 8'hFD;
  localparam logic [ByteW-1:0] ByteAbort     = 8'hFF;
  localparam logic [ByteW-1:0] ByteTxOn      = 8'h01;
  localparam logic [ByteW-1:0] AddrBroadcast = 8'h00;
  localparam logic [ByteW-1:0] AddrUnknown   = 8'h00;

  // Register reset values.
  localparam logic [ByteW-1:0] RstControllerAddr = 8'hE0;
  localparam logic [ByteW-1:0] RstCodeXferFreq   = 8'h00;
  localparam logic [ByteW-1:0] RstCodeReadFreq   = 8'h03;
  localparam logic [ByteW-1:0] RstCodeXferMode   = 8'h01;
  localparam logic [ByteW-1:0] RstCodeReadMode   = 8'h04;
  localparam logic [ByteW-1:0] RstCodeTxState    = 8'h1C;
  localparam logic [ByteW-1:0] RstCodeMeter      = 8'h15;

  // Input operation codes.
  typedef enum logic {
    OP_RX_BYTE    = 1'b0,
    OP_LINK_CLOSE = 1'b1
  } op_e;

  // Result kinds.
  typedef enum logic {
    KIND_STATUS = 1'b0,
    KIND_METER  = 1'b1
  } kind_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_CONTROLLER_ADDR = 3'd0,
    CFG_CODE_XFER_FREQ  = 3'd1,
    CFG_CODE_READ_FREQ  = 3'd2,
    CFG_CODE_XFER_MODE  = 3'd3,
    CFG_CODE_READ_MODE  = 3'd4,
    CFG_CODE_TX_STATE   = 3'd5,
    CFG_CODE_METER      = 3'd6
  } cfg_index_e;

  // Decimal weight of each frequency digit, least significant first.
  localparam logic [2*5-1:0][FreqW-1:0] FreqWeight = {
    34'd1000000000, 34'd100000000, 34'd10000000, 34'd1000000, 34'd100000,
    34'd10000,      34'd1000,      34'd100,      34'd10,       34'd1
  };

  typedef logic [KeepBytes-1:0][ByteW-1:0] frame_t;

  // Configuration register set.
  typedef struct packed {
    logic [ByteW-1:0] controller_addr;
    logic [ByteW-1:0] code_xfer_freq;
    logic [ByteW-1:0] code_read_freq;
    logic [ByteW-1:0] code_xfer_mode;
    logic [ByteW-1:0] code_read_mode;
    logic [ByteW-1:0] code_tx_state;
    logic [ByteW-1:0] code_meter;
  } cfg_t;

  // Outcome of evaluating one complete frame.
  typedef struct packed {
    logic              result;
    kind_e             kind;
    logic              learn_en;
    logic [ByteW-1:0]  learn_addr;
    logic              freq_we;
    logic [FreqW-1:0]  freq;
    logic              mode_we;
    logic [ByteW-1:0]  mode;
    logic [ByteW-1:0]  filter;
    logic              tx_we;
    logic              tx;
    logic [ByteW-1:0]  meter_kind;
    logic [MeterW-1:0] meter_value;
  } eval_t;

endpackage

FILE: rtl/core/rcat_frame_eval.sv
// Combinational evaluation of one complete frame: checks, address learning and field decode.
module rcat_frame_eval #(
  parameter int unsigned MAX_FRAME = rcat_pkg::MaxFrameDefault
) (
  input  rcat_pkg::frame_t                    frame_i,
  input  logic [$clog2(MAX_FRAME+1):0]        len_i,
  input  logic [rcat_pkg::ByteW-1:0]          learned_i,
  input  rcat_pkg::cfg_t                      cfg_i,
  output rcat_pkg::eval_t                     eval_o
);

  localparam int unsigned LenW = $clog2(MAX_FRAME + 1) + 1;

  logic                            header_ok;
  logic                            source_ok;
  logic                            dest_ok;
  logic                            is_freq;
  logic                            is_mode;
  logic                            is_tx;
  logic                            is_meter;
  logic [rcat_pkg::FreqW-1:0]      freq_sum;
  logic [rcat_pkg::MeterW-1:0]     meter_sum;
  logic                            meter_stop;
  logic [3:0][3:0]                 meter_nib;

  // Frame header and addressing.
  assign header_ok = (len_i >= LenW'(5)) &&
                     (frame_i[0] == rcat_pkg::BytePreamble) &&
                     (frame_i[1] == rcat_pkg::BytePreamble);
  assign source_ok = (frame_i[3] == learned_i) ||
                     ((learned_i == rcat_pkg::AddrUnknown) &&
                      (frame_i[4] == cfg_i.code_read_freq));
  assign dest_ok   = (frame_i[2] == cfg_i.controller_addr) ||
                     (frame_i[2] == rcat_pkg::AddrBroadcast);

  // Command decode in priority order: frequency, mode, transmit, meter.
  assign is_freq  = (frame_i[4] == cfg_i.code_xfer_freq) ||
                    (frame_i[4] == cfg_i.code_read_freq);
  assign is_mode  = !is_freq && ((frame_i[4] == cfg_i.code_xfer_mode) ||
                                 (frame_i[4] == cfg_i.code_read_mode));
  assign is_tx    = !is_freq && !is_mode && (frame_i[4] == cfg_i.code_tx_state);
  assign is_meter = !is_freq && !is_mode && !is_tx && (frame_i[4] == cfg_i.code_meter);

  // Frequency from five BCD bytes; an end-marker byte contributes nothing.
  always_comb begin
    freq_sum = '0;
    for (int i = 0; i < 5; i++) begin
      if (frame_i[5+i] != rcat_pkg::ByteEnd) begin
        freq_sum = freq_sum
                 + (rcat_pkg::FreqW'(frame_i[5+i][7:4]) * rcat_pkg::FreqWeight[2*i+1])
                 + (rcat_pkg::FreqW'(frame_i[5+i][3:0]) * rcat_pkg::FreqWeight[2*i]);
      end
    end
  end

  // Meter value: leading decimal digits, stopping at the first non-decimal nibble.
  assign meter_nib = {frame_i[7][3:0], frame_i[7][7:4], frame_i[6][3:0], frame_i[6][7:4]};

  always_comb begin
    meter_sum  = '0;
    meter_stop = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (!meter_stop) begin
        if (meter_nib[i] > 4'd9) begin
          meter_stop = 1'b1;
        end else begin
          meter_sum = rcat_pkg::MeterW'(meter_sum * rcat_pkg::MeterW'(10))
                    + rcat_pkg::MeterW'(meter_nib[i]);
        end
      end
    end
  end

  // Assemble the outcome.
  always_comb begin
    eval_o             = '0;
    eval_o.kind        = rcat_pkg::KIND_STATUS;
    eval_o.learn_addr  = frame_i[3];
    eval_o.freq        = freq_sum;
    eval_o.mode        = frame_i[5];
    eval_o.filter      = frame_i[6];
    eval_o.tx          = (frame_i[7] == rcat_pkg::ByteTxOn);
    if (header_ok && source_ok) begin
      eval_o.learn_en = (learned_i == rcat_pkg::AddrUnknown) &&
                        (frame_i[3] != rcat_pkg::AddrUnknown);
      if (dest_ok) begin
        if (is_freq && (len_i >= LenW'(10))) begin
          eval_o.freq_we = 1'b1;
          eval_o.result  = 1'b1;
        end
        if (is_mode && (len_i >= LenW'(7))) begin
          eval_o.mode_we = 1'b1;
          eval_o.result  = 1'b1;
        end
        if (is_tx && (len_i >= LenW'(8))) begin
          eval_o.tx_we  = 1'b1;
          eval_o.result = 1'b1;
        end
        if (is_meter && (len_i >= LenW'(8))) begin
          eval_o.kind        = rcat_pkg::KIND_METER;
          eval_o.meter_kind  = frame_i[5];
          eval_o.meter_value = meter_sum;
          eval_o.result      = 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/core/radio_cat_frame_decoder.sv
// Top level of the radio control-bus frame decoder.
// Takes one bus byte or link-close event per cycle and sustains one transfer per cycle on
// each side while neither stall is raised. An accepted item sits in the input register,
// where a single combinational pass collects the byte into the frame, checks a finished
// frame and updates the kept frequency, mode, filter, transmit flag and radio address; a
// result is loaded into the output register when the input register advances.
// The input register doubles as a skid stage, so one more item is taken while a result
// waits. Frames end at 0xFD or 0xFF; frames longer than MAX_FRAME bytes are dropped. The
// configuration registers should be written only while no item is in flight.
module radio_cat_frame_decoder #(
  parameter int unsigned MAX_FRAME = rcat_pkg::MaxFrameDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write port.
  input  logic                             cfg_we_i,
  input  logic [rcat_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [rcat_pkg::ByteW-1:0]       cfg_wdata_i,
  // Input channel.
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             operation_i,
  input  logic [rcat_pkg::ByteW-1:0]       rx_byte_i,
  // Result channel.
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             report_kind_o,
  output logic [rcat_pkg::FreqW-1:0]       frequency_hz_o,
  output logic [rcat_pkg::ByteW-1:0]       modulation_o,
  output logic [rcat_pkg::ByteW-1:0]       filter_width_o,
  output logic                             transmitting_o,
  output logic [rcat_pkg::ByteW-1:0]       meter_kind_o,
  output logic [rcat_pkg::MeterW-1:0]      meter_value_o,
  output logic [rcat_pkg::ByteW-1:0]       radio_address_o
);

  localparam int unsigned LenW = $clog2(MAX_FRAME + 1);

  rcat_pkg::cfg_t                  cfg_q;

  logic                            in_valid_q;
  logic                            in_op_q;
  logic [rcat_pkg::ByteW-1:0]      in_byte_q;

  logic [LenW-1:0]                 frame_len_q;
  logic [LenW-1:0]                 frame_len_d;
  rcat_pkg::frame_t                frame_q;
  rcat_pkg::frame_t                frame_view;
  logic [LenW:0]                   len_total;

  logic [rcat_pkg::ByteW-1:0]      learned_q;
  logic [rcat_pkg::ByteW-1:0]      learned_d;
  logic [rcat_pkg::FreqW-1:0]      freq_q;
  logic [rcat_pkg::FreqW-1:0]      freq_d;
  logic [rcat_pkg::ByteW-1:0]      mode_q;
  logic [rcat_pkg::ByteW-1:0]      mode_d;
  logic [rcat_pkg::ByteW-1:0]      filter_q;
  logic [rcat_pkg::ByteW-1:0]      filter_d;
  logic                            tx_q;
  logic                            tx_d;

  logic                            out_valid_q;
  logic                            out_kind_q;
  logic [rcat_pkg::FreqW-1:0]      out_freq_q;
  logic [rcat_pkg::ByteW-1:0]      out_mode_q;
  logic [rcat_pkg::ByteW-1:0]      out_filter_q;
  logic                            out_tx_q;
  logic [rcat_pkg::ByteW-1:0]      out_meter_kind_q;
  logic [rcat_pkg::MeterW-1:0]     out_meter_value_q;
  logic [rcat_pkg::ByteW-1:0]      out_addr_q;

  rcat_pkg::eval_t                 eval;
  logic                            is_byte;
  logic                            is_end;
  logic                            frame_use;
  logic                            res_valid;
  logic                            out_free;
  logic                            advance;
  logic                            in_accept;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.controller_addr <= rcat_pkg::RstControllerAddr;
      cfg_q.code_xfer_freq  <= rcat_pkg::RstCodeXferFreq;
      cfg_q.code_read_freq  <= rcat_pkg::RstCodeReadFreq;
      cfg_q.code_xfer_mode  <= rcat_pkg::RstCodeXferMode;
      cfg_q.code_read_mode  <= rcat_pkg::RstCodeReadMode;
      cfg_q.code_tx_state   <= rcat_pkg::RstCodeTxState;
      cfg_q.code_meter      <= rcat_pkg::RstCodeMeter;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        rcat_pkg::CFG_CONTROLLER_ADDR: cfg_q.controller_addr <= cfg_wdata_i;
        rcat_pkg::CFG_CODE_XFER_FREQ:  cfg_q.code_xfer_freq  <= cfg_wdata_i;
        rcat_pkg::CFG_CODE_READ_FREQ:  cfg_q.code_read_freq  <= cfg_wdata_i;
        rcat_pkg::CFG_CODE_XFER_MODE:  cfg_q.code_xfer_mode  <= cfg_wdata_i;
        rcat_pkg::CFG_CODE_READ_MODE:  cfg_q.code_read_mode  <= cfg_wdata_i;
        rcat_pkg::CFG_CODE_TX_STATE:   cfg_q.code_tx_state   <= cfg_wdata_i;
        rcat_pkg::CFG_CODE_METER:      cfg_q.code_meter      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Handshake: the input register advances unless its result has nowhere to go.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && (out_free || !res_valid);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_op_q   <= operation_i;
      in_byte_q <= rx_byte_i;
    end
  end

  // Frame view with the current byte placed at its position.
  always_comb begin
    for (int i = 0; i < rcat_pkg::KeepBytes; i++) begin
      frame_view[i] = (frame_len_q == LenW'(i)) ? in_byte_q : frame_q[i];
    end
  end

  assign is_byte   = (in_op_q == rcat_pkg::OP_RX_BYTE);
  assign is_end    = (in_byte_q == rcat_pkg::ByteEnd) || (in_byte_q == rcat_pkg::ByteAbort);
  assign len_total = {1'b0, frame_len_q} + (LenW+1)'(1);
  assign frame_use = is_byte && is_end && (len_total <= (LenW+1)'(MAX_FRAME));
  assign res_valid = frame_use && eval.result;

  rcat_frame_eval #(
    .MAX_FRAME (MAX_FRAME)
  ) u_frame_eval (
    .frame_i   (frame_view),
    .len_i     (len_total),
    .learned_i (learned_q),
    .cfg_i     (cfg_q),
    .eval_o    (eval)
  );

  // Next values of the length counter and the kept state.
  always_comb begin
    frame_len_d = frame_len_q;
    learned_d   = learned_q;
    freq_d      = freq_q;
    mode_d      = mode_q;
    filter_d    = filter_q;
    tx_d        = tx_q;
    if (!is_byte) begin
      learned_d = rcat_pkg::AddrUnknown;
    end else begin
      if (is_end) begin
        frame_len_d = '0;
      end else if (frame_len_q < LenW'(MAX_FRAME)) begin
        frame_len_d = frame_len_q + LenW'(1);
      end
      if (frame_use) begin
        if (eval.learn_en) learned_d = eval.learn_addr;
        if (eval.freq_we)  freq_d    = eval.freq;
        if (eval.mode_we) begin
          mode_d   = eval.mode;
          filter_d = eval.filter;
        end
        if (eval.tx_we)    tx_d      = eval.tx;
      end
    end
  end

  // Kept state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_len_q <= '0;
      learned_q   <= rcat_pkg::AddrUnknown;
      freq_q      <= '0;
      mode_q      <= '0;
      filter_q    <= '0;
      tx_q        <= 1'b0;
    end else if (advance) begin
      frame_len_q <= frame_len_d;
      learned_q   <= learned_d;
      freq_q      <= freq_d;
      mode_q      <= mode_d;
      filter_q    <= filter_d;
      tx_q        <= tx_d;
    end
  end

  // Storage for the first bytes of the frame.
  always_ff @(posedge clk_i) begin
    if (advance && is_byte && (frame_len_q < LenW'(rcat_pkg::KeepBytes))) begin
      frame_q[frame_len_q[rcat_pkg::KeepIdxW-1:0]] <= in_byte_q;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_kind_q        <= eval.kind;
      out_freq_q        <= freq_d;
      out_mode_q        <= mode_d;
      out_filter_q      <= filter_d;
      out_tx_q          <= tx_d;
      out_meter_kind_q  <= eval.meter_kind;
      out_meter_value_q <= eval.meter_value;
      out_addr_q        <= learned_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign report_kind_o   = out_kind_q;
  assign frequency_hz_o  = out_freq_q;
  assign modulation_o    = out_mode_q;
  assign filter_width_o  = out_filter_q;
  assign transmitting_o  = out_tx_q;
  assign meter_kind_o    = out_meter_kind_q;
  assign meter_value_o   = out_meter_value_q;
  assign radio_address_o = out_addr_q;

endmodule

FILE: bench/radio_cat_frame_checker.sv
`timescale 1ns / 1ps
// Checker of the radio control-bus frame decoder: predicts each report and compares transfers.
module radio_cat_frame_checker
  import rcat_pkg::*;
#(
  parameter int unsigned MAX_FRAME = MaxFrameDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration writes as the block sees them.
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ByteW-1:0]   cfg_wdata_i,
  // Input channel.
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic               operation_i,
  input  logic [ByteW-1:0]   rx_byte_i,
  // Result channel.
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic               report_kind_i,
  input  logic [FreqW-1:0]   frequency_hz_i,
  input  logic [ByteW-1:0]   modulation_i,
  input  logic [ByteW-1:0]   filter_width_i,
  input  logic               transmitting_i,
  input  logic [ByteW-1:0]   meter_kind_i,
  input  logic [MeterW-1:0]  meter_value_i,
  input  logic [ByteW-1:0]   radio_address_i,
  // Reports still owed by the block, and mismatches seen so far.
  output int                 pending_o,
  output int                 mismatches_o
);

  // One report as the block should deliver it.
  typedef struct packed {
    kind_e             kind;
    logic [FreqW-1:0]  freq;
    logic [ByteW-1:0]  mode;
    logic [ByteW-1:0]  filter;
    logic              tx;
    logic [ByteW-1:0]  meter_kind;
    logic [MeterW-1:0] meter_value;
    logic [ByteW-1:0]  addr;
  } decoder_report_t;

  decoder_report_t  due_reports[$];
  int               mismatches = 0;

  // Shadow of the block's registers and kept state.
  cfg_t             regs;
  int unsigned      frm_len;
  logic [ByteW-1:0] frm_bytes [KeepBytes];
  logic [ByteW-1:0] radio_addr;
  logic [FreqW-1:0] kept_freq;
  logic [ByteW-1:0] kept_mode;
  logic [ByteW-1:0] kept_filter;
  logic             kept_tx;

  assign mismatches_o = mismatches;

  task automatic flag_mismatch(input string what, input longint unsigned got,
                               input longint unsigned want);
    $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    mismatches++;
  endtask

  // Runs one accepted item through the frame logic and queues the report it causes.
  task automatic absorb_item(input logic op, input logic [ByteW-1:0] b);
    int unsigned     len;
    int              i;
    logic [7:0]      cmd;
    logic [63:0]     sum;
    logic [63:0]     w;
    logic [3:0]      nib [4];
    int unsigned     mval;
    decoder_report_t rep;
    if (op == OP_LINK_CLOSE) begin
      radio_addr = AddrUnknown;
      return;
    end
    if (frm_len < KeepBytes) frm_bytes[frm_len] = b;
    if (b != ByteEnd && b != ByteAbort) begin
      if (frm_len < MAX_FRAME) frm_len++;
      return;
    end
    len = frm_len + 1;
    frm_len = 0;
    if (len > MAX_FRAME || len < 5) return;
    if (frm_bytes[0] != BytePreamble || frm_bytes[1] != BytePreamble) return;
    // The sender must be the known radio, or a frequency reply may introduce it.
    if (!(frm_bytes[3] == radio_addr ||
          (radio_addr == AddrUnknown && frm_bytes[4] == regs.code_read_freq))) return;
    if (radio_addr == AddrUnknown && frm_bytes[3] != AddrUnknown) radio_addr = frm_bytes[3];
    if (frm_bytes[2] != regs.controller_addr && frm_bytes[2] != AddrBroadcast) return;
    cmd = frm_bytes[4];
    rep.kind = KIND_STATUS;
    rep.meter_kind = '0;
    rep.meter_value = '0;
    // Command codes are tried in a fixed order; the first match wins.
    if (cmd == regs.code_xfer_freq || cmd == regs.code_read_freq) begin
      if (len < 10) return;
      sum = '0;
      w = 64'd1000000000;
      for (i = 0; i < 5; i++) begin
        if (frm_bytes[9-i] != ByteEnd) begin
          sum += 64'(frm_bytes[9-i][7:4]) * w + 64'(frm_bytes[9-i][3:0]) * (w / 10);
        end
        w = w / 100;
      end
      kept_freq = sum[FreqW-1:0];
    end else if (cmd == regs.code_xfer_mode || cmd == regs.code_read_mode) begin
      if (len < 7) return;
      kept_mode = frm_bytes[5];
      kept_filter = frm_bytes[6];
    end else if (cmd == regs.code_tx_state) begin
      if (len < 8) return;
      kept_tx = (frm_bytes[7] == ByteTxOn);
    end else if (cmd == regs.code_meter) begin
      if (len < 8) return;
      nib[0] = frm_bytes[6][7:4];
      nib[1] = frm_bytes[6][3:0];
      nib[2] = frm_bytes[7][7:4];
      nib[3] = frm_bytes[7][3:0];
      // Decimal digits count only up to the first nibble that is not one.
      mval = 0;
      for (i = 0; i < 4; i++) begin
        if (nib[i] > 4'd9) break;
        mval = mval * 10 + nib[i];
      end
      rep.kind = KIND_METER;
      rep.meter_kind = frm_bytes[5];
      rep.meter_value = mval[MeterW-1:0];
    end else begin
      return;
    end
    rep.freq = kept_freq;
    rep.mode = kept_mode;
    rep.filter = kept_filter;
    rep.tx = kept_tx;
    rep.addr = radio_addr;
    due_reports.push_back(rep);
  endtask

  // Compare delivered reports first, then track writes and new input transfers.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    decoder_report_t want;
    if (!rst_ni) begin
      regs.controller_addr = RstControllerAddr;
      regs.code_xfer_freq = RstCodeXferFreq;
      regs.code_read_freq = RstCodeReadFreq;
      regs.code_xfer_mode = RstCodeXferMode;
      regs.code_read_mode = RstCodeReadMode;
      regs.code_tx_state = RstCodeTxState;
      regs.code_meter = RstCodeMeter;
      frm_len = 0;
      foreach (frm_bytes[k]) frm_bytes[k] = '0;
      radio_addr = AddrUnknown;
      kept_freq = '0;
      kept_mode = '0;
      kept_filter = '0;
      kept_tx = 1'b0;
      due_reports.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (due_reports.size() == 0) begin
          flag_mismatch("result transfer with no report due", frequency_hz_i, 0);
        end else begin
          want = due_reports.pop_front();
          if (report_kind_i !== want.kind) flag_mismatch("report_kind", report_kind_i, want.kind);
          if (frequency_hz_i !== want.freq) flag_mismatch("frequency_hz", frequency_hz_i, want.freq);
          if (modulation_i !== want.mode) flag_mismatch("modulation", modulation_i, want.mode);
          if (filter_width_i !== want.filter) flag_mismatch("filter_width", filter_width_i, want.filter);
          if (transmitting_i !== want.tx) flag_mismatch("transmitting", transmitting_i, want.tx);
          if (meter_kind_i !== want.meter_kind) begin
            flag_mismatch("meter_kind", meter_kind_i, want.meter_kind);
          end
          if (meter_value_i !== want.meter_value) begin
            flag_mismatch("meter_value", meter_value_i, want.meter_value);
          end
          if (radio_address_i !== want.addr) flag_mismatch("radio_address", radio_address_i, want.addr);
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_e'(cfg_index_i))
          CFG_CONTROLLER_ADDR: regs.controller_addr = cfg_wdata_i;
          CFG_CODE_XFER_FREQ:  regs.code_xfer_freq = cfg_wdata_i;
          CFG_CODE_READ_FREQ:  regs.code_read_freq = cfg_wdata_i;
          CFG_CODE_XFER_MODE:  regs.code_xfer_mode = cfg_wdata_i;
          CFG_CODE_READ_MODE:  regs.code_read_mode = cfg_wdata_i;
          CFG_CODE_TX_STATE:   regs.code_tx_state = cfg_wdata_i;
          CFG_CODE_METER:      regs.code_meter = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) absorb_item(operation_i, rx_byte_i);
      pending_o <= due_reports.size();
    end
  end

endmodule

FILE: bench/tb_radio_cat_frame_decoder.sv
`timescale 1ns / 1ps
// Testbench top of the radio control-bus frame decoder: stimulus, idling and the verdict.
module tb_radio_cat_frame_decoder;
  import rcat_pkg::*;

  localparam int unsigned MaxFrame   = MaxFrameDefault;
  localparam int unsigned PhaseItems = 290;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [ByteW-1:0]   cfg_wdata_i = '0;
  logic               in_valid_i = 1'b0;
  logic               operation_i = 1'b0;
  logic [ByteW-1:0]   rx_byte_i = '0;
  logic               out_stall_i = 1'b0;
  logic               in_stall_o;
  logic               out_valid_o;
  logic               report_kind_o;
  logic [FreqW-1:0]   frequency_hz_o;
  logic [ByteW-1:0]   modulation_o;
  logic [ByteW-1:0]   filter_width_o;
  logic               transmitting_o;
  logic [ByteW-1:0]   meter_kind_o;
  logic [MeterW-1:0]  meter_value_o;
  logic [ByteW-1:0]   radio_address_o;

  int                 pending;
  int                 mismatches;
  bit                 calm = 1'b0;
  int unsigned        items_sent = 0;
  logic [ByteW-1:0]   cfg_now [7];
  logic [ByteW-1:0]   radio_id;
  logic [ByteW-1:0]   frame_q[$];

  radio_cat_frame_decoder #(.MAX_FRAME(MaxFrame)) DUT (.*);

  radio_cat_frame_checker #(.MAX_FRAME(MaxFrame)) u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_i(in_stall_o), .operation_i, .rx_byte_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .report_kind_i(report_kind_o), .frequency_hz_i(frequency_hz_o),
    .modulation_i(modulation_o), .filter_width_i(filter_width_o),
    .transmitting_i(transmitting_o), .meter_kind_i(meter_kind_o),
    .meter_value_i(meter_value_o), .radio_address_i(radio_address_o),
    .pending_o(pending), .mismatches_o(mismatches)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs.
  initial begin
    #3000000;
    $display("radio_cat_frame_decoder test failed");
    $finish;
  end

  // The result side stalls now and then, except during the calm stretch.
  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 7);
  end

  function automatic logic [ByteW-1:0] body_byte();
    logic [ByteW-1:0] v;
    do v = 8'($urandom_range(0, 255)); while (v == ByteEnd || v == ByteAbort);
    return v;
  endfunction

  function automatic logic [ByteW-1:0] bcd_byte();
    return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
  endfunction

  // Offers one item, after an occasional idle gap, and waits for its transfer.
  task automatic send_item(input op_e op, input logic [ByteW-1:0] b);
    while (!calm && $urandom_range(0, 99) < 7) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    rx_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_q[k]) begin
      // A link can drop in the middle of a frame.
      if ($urandom_range(0, 199) == 0) send_item(OP_LINK_CLOSE, 8'($urandom_range(0, 255)));
      send_item(OP_RX_BYTE, frame_q[k]);
    end
  endtask

  // Stops offering items and lets the block empty out.
  task automatic settle();
    int unsigned guard;
    in_valid_i <= 1'b0;
    guard = 0;
    @(posedge clk_i);
    while (pending != 0 && guard < 4000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_index_e idx, input logic [ByteW-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= v;
    cfg_now[idx] = v;
    @(posedge clk_i);
  endtask

  task automatic program_registers(input logic [ByteW-1:0] ctrl, input logic [ByteW-1:0] xf,
                                   input logic [ByteW-1:0] rf, input logic [ByteW-1:0] xm,
                                   input logic [ByteW-1:0] rm, input logic [ByteW-1:0] txs,
                                   input logic [ByteW-1:0] mtr);
    settle();
    write_reg(CFG_CONTROLLER_ADDR, ctrl);
    write_reg(CFG_CODE_XFER_FREQ, xf);
    write_reg(CFG_CODE_READ_FREQ, rf);
    write_reg(CFG_CODE_XFER_MODE, xm);
    write_reg(CFG_CODE_READ_MODE, rm);
    write_reg(CFG_CODE_TX_STATE, txs);
    write_reg(CFG_CODE_METER, mtr);
    cfg_we_i <= 1'b0;
  endtask

  // Builds a mostly well-formed frame with random content into frame_q.
  task automatic build_frame();
    int unsigned r;
    int unsigned pick;
    int unsigned pay_len;
    int unsigned want;
    int          i;
    logic [7:0]  cmd;
    frame_q.delete();
    frame_q.push_back(($urandom_range(0, 99) < 4) ? body_byte() : BytePreamble);
    frame_q.push_back(($urandom_range(0, 99) < 4) ? body_byte() : BytePreamble);
    r = $urandom_range(0, 99);
    frame_q.push_back(r < 78 ? cfg_now[CFG_CONTROLLER_ADDR] :
                      (r < 92 ? AddrBroadcast : body_byte()));
    r = $urandom_range(0, 99);
    frame_q.push_back(r < 85 ? radio_id : (r < 92 ? AddrUnknown : body_byte()));
    // Choose the command: 0 frequency, 1 mode, 2 transmit, 3 meter, 4 anything.
    r = $urandom_range(0, 99);
    if (r < 20) begin
      cmd = cfg_now[CFG_CODE_READ_FREQ];
      pick = 0;
    end else if (r < 35) begin
      cmd = cfg_now[CFG_CODE_XFER_FREQ];
      pick = 0;
    end else if (r < 48) begin
      cmd = cfg_now[CFG_CODE_XFER_MODE];
      pick = 1;
    end else if (r < 60) begin
      cmd = cfg_now[CFG_CODE_READ_MODE];
      pick = 1;
    end else if (r < 74) begin
      cmd = cfg_now[CFG_CODE_TX_STATE];
      pick = 2;
    end else if (r < 90) begin
      cmd = cfg_now[CFG_CODE_METER];
      pick = 3;
    end else begin
      cmd = body_byte();
      pick = 4;
    end
    frame_q.push_back(cmd);
    case (pick)
      0: pay_len = 5;
      1: pay_len = 2;
      2, 3: pay_len = 3;
      default: pay_len = $urandom_range(0, 6);
    endcase
    for (i = 0; i < int'(pay_len); i++) begin
      if (pick == 0) begin
        frame_q.push_back(($urandom_range(0, 99) < 90) ? bcd_byte() : body_byte());
      end else if (pick == 2 && i == 2) begin
        r = $urandom_range(0, 99);
        frame_q.push_back(r < 45 ? ByteTxOn : (r < 80 ? 8'h00 : body_byte()));
      end else if (pick == 3 && i > 0) begin
        frame_q.push_back(($urandom_range(0, 99) < 80) ? bcd_byte() : body_byte());
      end else begin
        frame_q.push_back(body_byte());
      end
    end
    // Short frames, padded frames and frames around the length limit.
    r = $urandom_range(0, 99);
    if (r < 10) begin
      repeat ($urandom_range(1, 3)) begin
        if (frame_q.size() > 3) void'(frame_q.pop_back());
      end
    end else if (r < 20) begin
      repeat ($urandom_range(1, 8)) frame_q.push_back(body_byte());
    end else if (r < 22) begin
      want = $urandom_range(MaxFrame - 4, MaxFrame + 4);
      while (frame_q.size() < want - 1) frame_q.push_back(body_byte());
    end
    frame_q.push_back(($urandom_range(0, 99) < 85) ? ByteEnd : ByteAbort);
  endtask

  // Random traffic: mostly frames, some stray bytes and link closes.
  task automatic run_traffic(input int unsigned quota);
    int unsigned stop_at;
    int unsigned r;
    stop_at = items_sent + quota;
    send_item(OP_LINK_CLOSE, 8'($urandom_range(0, 255)));
    while (items_sent < stop_at) begin
      calm = (items_sent >= 700 && items_sent < 1000);
      r = $urandom_range(0, 99);
      if (r < 4) begin
        send_item(OP_LINK_CLOSE, 8'($urandom_range(0, 255)));
      end else if (r < 9) begin
        repeat ($urandom_range(1, 5)) send_item(OP_RX_BYTE, 8'($urandom_range(0, 255)));
      end else begin
        build_frame();
        send_frame();
      end
    end
    calm = 1'b0;
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset values, written explicitly.
    program_registers(RstControllerAddr, RstCodeXferFreq, RstCodeReadFreq, RstCodeXferMode,
                      RstCodeReadMode, RstCodeTxState, RstCodeMeter);
    radio_id = 8'h94;

    // A frequency reply teaches the address; the last digit byte is the end byte and skipped.
    frame_q = '{BytePreamble, BytePreamble, cfg_now[CFG_CONTROLLER_ADDR], radio_id,
                cfg_now[CFG_CODE_READ_FREQ], 8'h99, 8'h99, 8'h99, 8'h99, ByteEnd};
    send_frame();
    // Broadcast meter reply whose digits stop at a non-decimal nibble.
    frame_q = '{BytePreamble, BytePreamble, AddrBroadcast, radio_id,
                cfg_now[CFG_CODE_METER], 8'h02, 8'h12, 8'hAF, ByteEnd};
    send_frame();
    // Link close forgets the radio, so the following mode reply is refused.
    send_item(OP_LINK_CLOSE, 8'h00);
    frame_q = '{BytePreamble, BytePreamble, cfg_now[CFG_CONTROLLER_ADDR], radio_id,
                cfg_now[CFG_CODE_READ_MODE], ByteAbort};
    send_frame();
    run_traffic(PhaseItems);

    // Extreme register values.
    program_registers(8'h00, 8'hFF, 8'h00, 8'h80, 8'h7F, 8'h01, 8'hFE);
    radio_id = 8'h01;
    run_traffic(PhaseItems);

    // Colliding command codes and the top controller address.
    program_registers(8'hFF, 8'h10, 8'h10, 8'h10, 8'h20, 8'h20, 8'h30);
    radio_id = 8'h7A;
    run_traffic(PhaseItems);

    // Random registers.
    program_registers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)));
    radio_id = body_byte();
    if (radio_id == AddrUnknown) radio_id = 8'h5A;
    run_traffic(PhaseItems);

    // Back to the usual codes with another radio.
    program_registers(RstControllerAddr, RstCodeXferFreq, RstCodeReadFreq, RstCodeXferMode,
                      RstCodeReadMode, RstCodeTxState, RstCodeMeter);
    radio_id = body_byte();
    if (radio_id == AddrUnknown) radio_id = 8'hA5;
    run_traffic(PhaseItems);

    settle();
    if (pending != 0) $display("%0d expected reports never arrived", pending);
    if (mismatches == 0 && pending == 0) begin
      $display("radio_cat_frame_decoder test passed");
    end else begin
      $display("radio_cat_frame_decoder test failed");
    end
    $finish;
  end

endmodule
